// ----- rtl/sorted_event_timer_queue_assert.svh -----
// ----------------------------------------------------------------------------
// Sorted event timer queue assertion macros
// Shared assertion forms, sampled on clk_i and disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef SORTED_EVENT_TIMER_QUEUE_ASSERT_SVH
`define SORTED_EVENT_TIMER_QUEUE_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define SETQ_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// consequent must hold in the cycle after the antecedent
`define SETQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/setq_pkg.sv -----
// ----------------------------------------------------------------------------
// Sorted event timer queue package
// Depth, field widths, status codes and the entry and command types.
// ----------------------------------------------------------------------------
package setq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int TimeW       = 48;
  localparam int HandlerW    = 8;
  localparam int ArgW        = 32;
  localparam int IdleW       = 16;
  localparam logic [IdleW-1:0] IdleReset = IdleW'(128);

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_NONPOS = 2'd2,
    ST_EMPTY  = 2'd3
  } status_e;

  typedef struct packed {
    logic [TimeW-1:0]    key;
    logic [HandlerW-1:0] handler;
    logic [ArgW-1:0]     arg;
  } entry_t;

  typedef struct packed {
    logic   ins;
    logic   pop;
    entry_t ent;
  } cmd_t;

endpackage

// ----- rtl/setq_req_if.sv -----
// ----------------------------------------------------------------------------
// Request channel
// Valid/ready channel carrying one insert or pop request word.
// ----------------------------------------------------------------------------
interface setq_req_if;
  logic        valid;
  logic        ready;
  logic        req_type;
  logic [47:0] requested_time;
  logic [47:0] pending_cycles;
  logic [7:0]  handler_id;
  logic signed [31:0] event_arg;

  modport source (output valid, req_type, requested_time, pending_cycles,
                  handler_id, event_arg, input ready);
  modport sink   (input valid, req_type, requested_time, pending_cycles,
                  handler_id, event_arg, output ready);
endinterface

// ----- rtl/setq_rsp_if.sv -----
// ----------------------------------------------------------------------------
// Response channel
// Valid/ready channel carrying one result word per request.
// ----------------------------------------------------------------------------
interface setq_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [47:0] run_cycles;
  logic [7:0]  out_handler_id;
  logic signed [31:0] out_event_arg;

  modport source (output valid, status, run_cycles, out_handler_id, out_event_arg,
                  input ready);
  modport sink   (input valid, status, run_cycles, out_handler_id, out_event_arg,
                  output ready);
endinterface

// ----- rtl/setq_cfg_if.sv -----
// ----------------------------------------------------------------------------
// Configuration channel
// Valid/ready write channel for the idle run length register.
// ----------------------------------------------------------------------------
interface setq_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] idle_run_cycles;

  modport source (output valid, idle_run_cycles, input ready);
  modport sink   (input valid, idle_run_cycles, output ready);
endinterface

// ----- rtl/setq_cell.sv -----
// ----------------------------------------------------------------------------
// Sorted queue cell
// One slot of the sorted chain: compares its key with an incoming one and
// keeps, takes the new entry, or shifts from a neighbor.
// ----------------------------------------------------------------------------
module setq_cell import setq_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  cmd_t   cmd_i,
  input  entry_t left_ent_i,
  input  logic   left_valid_i,
  input  logic   left_gt_i,
  input  entry_t right_ent_i,
  input  logic   right_valid_i,
  output entry_t ent_o,
  output logic   valid_o,
  output logic   gt_o
);

  entry_t ent_q, ent_d;
  logic   valid_q, valid_d;

  // slot is behind the new key (empty slots count as behind)
  assign gt_o = !valid_q || (ent_q.key > cmd_i.ent.key);

  always_comb begin
    ent_d   = ent_q;
    valid_d = valid_q;
    if (cmd_i.pop) begin
      ent_d   = right_ent_i;
      valid_d = right_valid_i;
    end else if (cmd_i.ins && gt_o) begin
      if (left_gt_i) begin
        ent_d   = left_ent_i;
        valid_d = left_valid_i;
      end else begin
        ent_d   = cmd_i.ent;
        valid_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    ent_q <= ent_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  assign ent_o   = ent_q;
  assign valid_o = valid_q;

endmodule

// ----- rtl/sorted_event_timer_queue.sv -----
// ----------------------------------------------------------------------------
// Sorted event timer queue
// Holds up to QUEUE_DEPTH timed events sorted by key in a chain of cells.
// ----------------------------------------------------------------------------
// Usage:
//   req: one word per request. req_type 0 inserts an event with key
//   requested_time - pending_cycles; req_type 1 pops the head.
//   rsp: exactly one word per request: status, run length, handler, argument.
//   cfg: writes idle_run_cycles, returned by a pop on an empty queue.
//   Write it only while no request is outstanding; it is always ready.
// Timing:
//   A request is applied to all cells in the cycle it is accepted; its
//   response word is valid in the next cycle. One request per cycle is taken
//   as long as the response register is empty or drained in the same cycle.
//   The path is one 48-bit subtract followed by the per-cell 48-bit compare.
// Reset:
//   All cells are empty and idle_run_cycles is 128.
// Stall:
//   While rsp is held off with a word pending, req.ready is low and the
//   queue contents do not change.
// ----------------------------------------------------------------------------
`include "sorted_event_timer_queue_assert.svh"

module sorted_event_timer_queue import setq_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  setq_req_if.sink   req,
  setq_rsp_if.source rsp,
  setq_cfg_if.sink   cfg
);

  logic [IdleW-1:0]       idle_q;
  logic                   rsp_valid_q;
  status_e                status_q, status_d;
  logic [TimeW-1:0]       run_q, run_d;
  logic [HandlerW-1:0]    hid_q, hid_d;
  logic [ArgW-1:0]        arg_q, arg_d;

  entry_t                 cell_ent [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0] cell_valid;
  logic [QUEUE_DEPTH-1:0] cell_gt;
  cmd_t                   cmd;

  logic accept, is_pop, full, empty, nonpos;

  assign cfg.ready = 1'b1;
  assign req.ready = !rsp_valid_q || rsp.ready;
  assign accept    = req.valid && req.ready;
  assign is_pop    = req.req_type;
  assign full      = cell_valid[QUEUE_DEPTH-1];
  assign empty     = !cell_valid[0];
  assign nonpos    = req.requested_time <= req.pending_cycles;

  always_comb begin
    cmd.ins         = accept && !is_pop && !full && !nonpos;
    cmd.pop         = accept && is_pop && !empty;
    cmd.ent.key     = req.requested_time - req.pending_cycles;
    cmd.ent.handler = req.handler_id;
    cmd.ent.arg     = req.event_arg;
  end

  for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
    entry_t left_ent, right_ent;
    logic   left_valid, left_gt, right_valid;
    if (g == 0) begin : g_first
      assign left_ent   = '0;
      assign left_valid = 1'b0;
      assign left_gt    = 1'b0;
    end else begin : g_mid
      assign left_ent   = cell_ent[g-1];
      assign left_valid = cell_valid[g-1];
      assign left_gt    = cell_gt[g-1];
    end
    if (g == QUEUE_DEPTH-1) begin : g_last
      assign right_ent   = '0;
      assign right_valid = 1'b0;
    end else begin : g_inner
      assign right_ent   = cell_ent[g+1];
      assign right_valid = cell_valid[g+1];
    end
    setq_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .cmd_i        (cmd),
      .left_ent_i   (left_ent),
      .left_valid_i (left_valid),
      .left_gt_i    (left_gt),
      .right_ent_i  (right_ent),
      .right_valid_i(right_valid),
      .ent_o        (cell_ent[g]),
      .valid_o      (cell_valid[g]),
      .gt_o         (cell_gt[g])
    );
  end

  always_comb begin
    status_d = ST_OK;
    run_d    = '0;
    hid_d    = '0;
    arg_d    = '0;
    if (is_pop) begin
      if (empty) begin
        status_d = ST_EMPTY;
        run_d    = TimeW'(idle_q);
      end else begin
        run_d = cell_ent[0].key;
        hid_d = cell_ent[0].handler;
        arg_d = cell_ent[0].arg;
      end
    end else if (full) begin
      status_d = ST_FULL;
    end else if (nonpos) begin
      status_d = ST_NONPOS;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
      idle_q      <= IdleReset;
    end else begin
      if (accept) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid_q <= 1'b0;
      end
      if (cfg.valid) begin
        idle_q <= cfg.idle_run_cycles;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q <= status_d;
      run_q    <= run_d;
      hid_q    <= hid_d;
      arg_q    <= arg_d;
    end
  end

  assign rsp.valid          = rsp_valid_q;
  assign rsp.status         = status_q;
  assign rsp.run_cycles     = run_q;
  assign rsp.out_handler_id = hid_q;
  assign rsp.out_event_arg  = arg_q;

  `SETQ_ASSERT_NOW(a_valid_prefix, 1'b1, ((cell_valid + 1'b1) & cell_valid) == '0, "valid cells not a prefix")
  `SETQ_ASSERT_NOW(a_head_sorted, cell_valid[1], cell_ent[0].key <= cell_ent[1].key, "head cells out of order")
  `SETQ_ASSERT_NEXT(a_empty_pop, accept && is_pop && empty, rsp.valid && rsp.status == ST_EMPTY, "empty pop not reported")
  `SETQ_ASSERT_NEXT(a_full_hold, accept && !is_pop && full, $stable(cell_valid), "full insert changed queue")

endmodule
